[design/swg_pkg.sv]
// ----------------------------------------------------------------------------
// swg_pkg: shared constants, types and sine table of the sine generator
// Holds the field widths, register indexes, setup sequencer states and the
// quarter-wave Q0.15 sine table built from a fixed-point Taylor series.
// ----------------------------------------------------------------------------
package swg_pkg;

  // timing of the trigger that paces the points
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned TIMER_CLOCK     = 120000000;
  localparam int unsigned TRIGGER_DIVIDE  = 8;
  localparam int unsigned POINT_RATE      = TIMER_CLOCK / TRIGGER_DIVIDE;
  localparam int unsigned DAC_MAX         = 4095;

  // field widths
  localparam int FREQ_W   = 24;
  localparam int LEVEL_W  = 12;
  localparam int SAMPLE_W = 13;
  localparam int SWING_W  = 11;
  localparam int SINE_W   = 16;
  localparam int PROD_W   = SWING_W + 1 + SINE_W;

  // sine table geometry: 1024 points per turn, quarter stored
  localparam int PHASE_W = 10;
  localparam int unsigned PHASE_POINTS = 1 << PHASE_W;
  localparam int QUARTER = PHASE_POINTS / 4;
  localparam int QIDX_W  = PHASE_W - 1;
  localparam logic [63:0] PI_Q48 = 64'h0003_243F_6A88_85A3;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FREQ_HZ      = 2'd0,
    REG_PEAK_LEVEL   = 2'd1,
    REG_TROUGH_LEVEL = 2'd2,
    REG_ENABLE       = 2'd3
  } reg_index_t;

  // setup sequencer states
  typedef enum logic [1:0] {
    SETUP_IDLE,
    SETUP_DIV_PERIOD,
    SETUP_DIV_STEP,
    SETUP_REPORT
  } setup_state_t;

  // wave settings handed from setup to the table fill
  typedef struct packed {
    logic                 valid;
    logic [SWING_W-1:0]   half_swing;
    logic [SAMPLE_W-1:0]  offset;
    logic [PHASE_W-1:0]   step_whole;
  } wave_cfg_t;

  typedef logic [SINE_W-2:0] quarter_table_t [QUARTER+1];

  // quarter wave round(32767*sin(pi*k/512)) via Q30 Taylor series
  function automatic quarter_table_t build_quarter_table();
    quarter_table_t    tab;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] acc;
    logic [63:0]       mag;
    int                k;
    int                n;
    for (k = 0; k <= QUARTER; k++) begin
      x    = (64'(k) * PI_Q48 + (64'd1 << 26)) >> 27;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc  = signed'(x);
      for (n = 1; n <= 8; n++) begin
        term = (term * x2 + (64'd1 << 29)) >> 30;
        case (n)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          7: term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if (n % 2 == 1) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      if (acc < 0) begin
        acc = 64'sd0;
      end
      mag    = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      tab[k] = mag[SINE_W-2:0];
    end
    return tab;
  endfunction

  localparam quarter_table_t QUARTER_SINE = build_quarter_table();

  // full-turn sine from the quarter table, signed Q1.15
  function automatic logic signed [SINE_W-1:0] sine_at(logic [PHASE_W-1:0] k);
    logic [QIDX_W-1:0]  idx;
    logic [SINE_W-2:0]  mag;
    logic [PHASE_W-3:0] off;
    off = k[PHASE_W-3:0];
    if (k[PHASE_W-2]) begin
      idx = QIDX_W'(QUARTER) - QIDX_W'(off);
    end else begin
      idx = QIDX_W'(off);
    end
    mag = QUARTER_SINE[idx];
    if (k[PHASE_W-1]) begin
      return -signed'({1'b0, mag});
    end else begin
      return signed'({1'b0, mag});
    end
  endfunction

endpackage

[design/swg_ifs.sv]
// ----------------------------------------------------------------------------
// swg channel interfaces
// Valid/ready channels for the tick requests and for the produced samples.
// ----------------------------------------------------------------------------
interface swg_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface swg_out_if;
  logic                          valid;
  logic                          ready;
  logic [swg_pkg::SAMPLE_W-1:0]  sample;
  logic                          active;
  logic                          settings_bad;
  logic                          period_end;

  modport source (output valid, output sample, output active, output settings_bad,
                  output period_end, input ready);
  modport sink   (input valid, input sample, input active, input settings_bad,
                  input period_end, output ready);
endinterface

[design/sine_waveform_generator_unit.sv]
// ----------------------------------------------------------------------------
// sine_waveform_generator_unit: periodic sine generator for a 12-bit DAC
// A request's sample passes the RAM read register, then the output register.
// Throughput: one request per cycle (single waveform RAM read port) unless
// setup is busy or the output is held. Rising enable: setup (two 11-step
// divisions, then the N-point table fill) takes no request; cfg writes go on.
// Reset: registers take their reset values, generator disabled, no output.
// ----------------------------------------------------------------------------
module sine_waveform_generator_unit #(
  parameter int unsigned TABLE_DEPTH = swg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  swg_in_if.sink                      in_ch,
  swg_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  swg_pkg::reg_index_t         cfg_index,
  input  logic [swg_pkg::FREQ_W-1:0]  cfg_data
);
  import swg_pkg::*;

  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  // configuration registers
  logic [FREQ_W-1:0]  freq_hz;
  logic [LEVEL_W-1:0] peak_level;
  logic [LEVEL_W-1:0] trough_level;
  logic               enable;

  logic               start;
  logic               setup_busy;
  logic               setup_done;
  wave_cfg_t          wave;
  logic [NW-1:0]      period;
  logic [NW-1:0]      step_frac;
  logic               fill_busy;
  logic               fill_start;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic [SAMPLE_W-1:0] rd_data;

  logic               settings_valid;
  logic [AW-1:0]      point_index;
  logic               running;
  logic               busy;
  logic               accept;
  logic               s1_move;

  logic               s1_valid;
  logic               s1_active;
  logic               s1_bad;
  logic               s1_end;
  logic               out_valid;
  logic [SAMPLE_W-1:0] out_sample;
  logic               out_active;
  logic               out_bad;
  logic               out_end;

  // register writes, enable rising edge starts setup
  assign start = cfg_we && (cfg_index == REG_ENABLE) && cfg_data[0] && !enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_hz      <= FREQ_W'(15000);
      peak_level   <= LEVEL_W'(4095);
      trough_level <= '0;
      enable       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_HZ:      freq_hz      <= cfg_data;
        REG_PEAK_LEVEL:   peak_level   <= cfg_data[LEVEL_W-1:0];
        REG_TROUGH_LEVEL: trough_level <= cfg_data[LEVEL_W-1:0];
        REG_ENABLE:       enable       <= cfg_data[0];
        default:          enable       <= enable;
      endcase
    end
  end

  swg_setup #(.TABLE_DEPTH(TABLE_DEPTH)) u_setup (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .freq_hz      (freq_hz),
    .peak_level   (peak_level),
    .trough_level (trough_level),
    .busy         (setup_busy),
    .done         (setup_done),
    .wave         (wave),
    .period       (period),
    .step_frac    (step_frac)
  );

  assign fill_start = setup_done && wave.valid && !start;

  swg_fill #(.TABLE_DEPTH(TABLE_DEPTH)) u_fill (
    .clk       (clk),
    .rst       (rst),
    .start     (fill_start),
    .stop      (start),
    .period    (period),
    .step_frac (step_frac),
    .wave      (wave),
    .busy      (fill_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // waveform table, one DAC code per point
  swg_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (point_index),
    .rd_data (rd_data)
  );

  // request handshake
  assign busy     = setup_busy | fill_busy;
  assign running  = enable && settings_valid;
  assign s1_move  = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !busy && (!s1_valid || s1_move);
  assign accept   = in_ch.valid && in_ch.ready;

  // settings status
  always_ff @(posedge clk) begin
    if (rst || start) begin
      settings_valid <= 1'b0;
    end else if (setup_done) begin
      settings_valid <= wave.valid;
    end
  end

  // point index, wraps at the period
  always_ff @(posedge clk) begin
    if (rst || start) begin
      point_index <= '0;
    end else if (accept && running && in_ch.advance) begin
      if ((NW'(point_index) + NW'(1)) == period) begin
        point_index <= '0;
      end else begin
        point_index <= point_index + AW'(1);
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_active <= running;
      s1_bad    <= enable && !settings_valid;
      s1_end    <= running && ((NW'(point_index) + NW'(1)) == period);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_sample <= s1_active ? rd_data : '0;
      out_active <= s1_active;
      out_bad    <= s1_bad;
      out_end    <= s1_end;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sample       = out_sample;
  assign out_ch.active       = out_active;
  assign out_ch.settings_bad = out_bad;
  assign out_ch.period_end   = out_end;

endmodule

[design/swg_ram.sv]
// ----------------------------------------------------------------------------
// swg_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swg_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/swg_setup.sv]
// ----------------------------------------------------------------------------
// swg_setup: settings check and derivation
// Checks the settings; if they pass, runs a restoring divider twice: once for
// period N = rate/freq and once for the phase step 1024/N (whole and rest).
// ----------------------------------------------------------------------------
module swg_setup #(
  parameter int unsigned TABLE_DEPTH = swg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [swg_pkg::FREQ_W-1:0]           freq_hz,
  input  logic [swg_pkg::LEVEL_W-1:0]          peak_level,
  input  logic [swg_pkg::LEVEL_W-1:0]          trough_level,
  output logic                                 busy,
  output logic                                 done,
  output swg_pkg::wave_cfg_t                   wave,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     period,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     step_frac
);
  import swg_pkg::*;

  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int QW  = (NW > PHASE_W + 1) ? NW : PHASE_W + 1;
  localparam int CW  = $clog2(QW);
  localparam int DVW = 32;
  localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);
  localparam int unsigned MIN_FREQ_EXCL = POINT_RATE / (TABLE_DEPTH + 1);

  setup_state_t state, state_next;

  logic [CW-1:0]      cnt;
  logic [FREQ_W-1:0]  rem;
  logic [DVW-1:0]     dvd;
  logic [QW-1:0]      quo;
  logic [FREQ_W-1:0]  divisor;
  logic               ok;
  logic [SWING_W-1:0] half;
  logic [SAMPLE_W-1:0] offs;
  logic [PHASE_W-1:0] step_whole;

  logic                check_ok;
  logic [LEVEL_W-1:0]  span;
  logic [SWING_W-1:0]  half_calc;
  logic [SAMPLE_W-1:0] offs_calc;
  logic [FREQ_W:0]     shifted;
  logic                fits;
  logic [FREQ_W-1:0]   rem_next;
  logic [QW-1:0]       quo_next;
  logic                dividing;

  // settings check and level arithmetic
  always_comb begin
    check_ok = (freq_hz != '0)
            && (32'(freq_hz) <= POINT_RATE)
            && (32'(freq_hz) > MIN_FREQ_EXCL)
            && (32'(peak_level) <= DAC_MAX)
            && (32'(trough_level) <= DAC_MAX)
            && (peak_level >= trough_level);
    span      = peak_level - trough_level;
    half_calc = span[LEVEL_W-1:1];
    offs_calc = SAMPLE_W'(peak_level) - SAMPLE_W'(half_calc) + SAMPLE_W'(1);
  end

  // one restoring division step
  always_comb begin
    shifted  = {rem, dvd[DVW-1]};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? FREQ_W'(shifted - {1'b0, divisor}) : shifted[FREQ_W-1:0];
    quo_next = {quo[QW-2:0], fits};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SETUP_IDLE:       state_next = SETUP_IDLE;
      SETUP_DIV_PERIOD: if (cnt == LAST_STEP) state_next = SETUP_DIV_STEP;
      SETUP_DIV_STEP:   if (cnt == LAST_STEP) state_next = SETUP_REPORT;
      SETUP_REPORT:     state_next = SETUP_IDLE;
      default:          state_next = SETUP_IDLE;
    endcase
    if (start) begin
      state_next = check_ok ? SETUP_DIV_PERIOD : SETUP_REPORT;
    end
  end

  // outputs of the sequencer
  always_comb begin
    busy     = 1'b1;
    done     = 1'b0;
    dividing = 1'b0;
    case (state)
      SETUP_IDLE:       busy = 1'b0;
      SETUP_DIV_PERIOD: dividing = 1'b1;
      SETUP_DIV_STEP:   dividing = 1'b1;
      SETUP_REPORT:     done = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SETUP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      ok      <= check_ok;
      half    <= half_calc;
      offs    <= offs_calc;
      rem     <= FREQ_W'(POINT_RATE >> QW);
      dvd     <= DVW'(POINT_RATE) << (DVW - QW);
      divisor <= freq_hz;
      cnt     <= '0;
    end else if (dividing) begin
      rem <= rem_next;
      dvd <= dvd << 1;
      quo <= quo_next;
      cnt <= cnt + CW'(1);
      if (cnt == LAST_STEP) begin
        cnt <= '0;
        if (state == SETUP_DIV_PERIOD) begin
          period  <= quo_next[NW-1:0];
          rem     <= '0;
          dvd     <= DVW'(PHASE_POINTS) << (DVW - QW);
          divisor <= FREQ_W'(quo_next[NW-1:0]);
        end else begin
          step_whole <= quo_next[PHASE_W-1:0];
          step_frac  <= rem_next[NW-1:0];
        end
      end
    end
  end

  assign wave = '{valid: ok, half_swing: half, offset: offs, step_whole: step_whole};

endmodule

[design/swg_fill.sv]
// ----------------------------------------------------------------------------
// swg_fill: waveform table fill
// Walks the N points of one period, tracks the table phase with a whole and
// fractional step, looks up the sine, scales and offsets it and writes the
// DAC code of each point into the waveform RAM.
// ----------------------------------------------------------------------------
module swg_fill #(
  parameter int unsigned TABLE_DEPTH = swg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 stop,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     period,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     step_frac,
  input  swg_pkg::wave_cfg_t                   wave,
  output logic                                 busy,
  output logic                                 wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
  output logic [swg_pkg::SAMPLE_W-1:0]         wr_data
);
  import swg_pkg::*;

  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  logic               run;
  logic [AW-1:0]      idx;
  logic [PHASE_W-1:0] phase;
  logic [NW-1:0]      frac;

  logic                     s1_valid;
  logic [AW-1:0]            s1_addr;
  logic signed [SINE_W-1:0] s1_sine;
  logic                     s2_valid;
  logic [AW-1:0]            s2_addr;
  logic signed [PROD_W-1:0] s2_prod;

  logic [NW:0]              frac_sum;
  logic                     carry;
  logic [NW-1:0]            frac_next;
  logic                     last_point;
  logic signed [PROD_W-1:0] scaled;
  logic signed [PROD_W-1:0] level;

  // phase step with remainder carry
  always_comb begin
    frac_sum   = {1'b0, frac} + {1'b0, step_frac};
    carry      = frac_sum >= {1'b0, period};
    frac_next  = carry ? NW'(frac_sum - {1'b0, period}) : frac_sum[NW-1:0];
    last_point = (NW'(idx) + NW'(1)) == period;
  end

  // point walker
  always_ff @(posedge clk) begin
    if (rst || stop) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && last_point) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx   <= '0;
      phase <= '0;
      frac  <= '0;
    end else if (run) begin
      idx   <= idx + AW'(1);
      phase <= phase + wave.step_whole + PHASE_W'(carry);
      frac  <= frac_next;
    end
  end

  // sine lookup and scaling stages
  always_ff @(posedge clk) begin
    if (rst || stop || start) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= run;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= idx;
    s1_sine <= sine_at(phase);
    s2_addr <= s1_addr;
    s2_prod <= signed'({1'b0, wave.half_swing}) * s1_sine;
  end

  // offset and write back, floor division by 32768
  always_comb begin
    scaled  = s2_prod >>> (SINE_W - 1);
    level   = signed'(PROD_W'(wave.offset)) + scaled;
    wr_en   = s2_valid;
    wr_addr = s2_addr;
    wr_data = level[SAMPLE_W-1:0];
  end

  assign busy = run | s1_valid | s2_valid;

endmodule
